// ===== hw/rtl/gds_pkg.sv =====
// Shared types, constants and small arithmetic functions for the Gregorian date step block.
package gds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int Y400_W  = 9;
    localparam int Y100_W  = 7;
    localparam int WSUM_W  = 12;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DEC_LEN   = 5'd31;

    // Days per month in a common year, indexed by the raw month code (0 for bad codes)
    localparam logic [DAY_W-1:0] BASE_LEN [0:15] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // Month offset floor((26*mm - 2) / 10) with mm = (month + 9) % 12 + 1, by raw month code
    localparam logic [DAY_W-1:0] MON_OFS [0:15] = '{
        5'd25, 5'd28, 5'd31, 5'd2,  5'd5,  5'd7,  5'd10, 5'd12,
        5'd15, 5'd18, 5'd20, 5'd23, 5'd25, 5'd28, 5'd31, 5'd2
    };

    // Per-item calendar results passed from the calendar stage to the weekday stage
    typedef struct packed {
        logic                 date_valid;
        logic                 leap_year;
        logic [DAY_W-1:0]     month_length;
        logic [WSUM_W-1:0]    wsum;
        logic [YEAR_W-1:0]    next_year;
        logic [MONTH_W-1:0]   next_month;
        logic [DAY_W-1:0]     next_day;
        logic [YEAR_W-1:0]    prev_year;
        logic [MONTH_W-1:0]   prev_month;
        logic [DAY_W-1:0]     prev_day;
    } gds_cal_t;

    // Year mod 400: (year / 16) mod 25 by reciprocal 41/1024 (exact below 1024), low nibble kept
    function automatic logic [Y400_W-1:0] mod400(input logic [YEAR_W-1:0] y);
        logic [9:0]  x;
        logic [15:0] prod;
        logic [5:0]  q;
        logic [9:0]  q25;
        logic [9:0]  r;
        x    = y[YEAR_W-1:4];
        prod = 16'(x) * 16'd41;
        q    = prod[15:10];
        q25  = (10'(q) << 4) + (10'(q) << 3) + 10'(q);
        r    = x - q25;
        return {r[4:0], y[3:0]};
    endfunction

    // Value below 100 mod 25 by compare and subtract
    function automatic logic [4:0] mod25(input logic [6:0] v);
        logic [6:0] r;
        if (v >= 7'd75)
            r = v - 7'd75;
        else if (v >= 7'd50)
            r = v - 7'd50;
        else if (v >= 7'd25)
            r = v - 7'd25;
        else
            r = v;
        return r[4:0];
    endfunction

    // Weighted sum mod 7 by reciprocal 2341/16384 (exact below 5461)
    function automatic logic [WDAY_W-1:0] mod7(input logic [WSUM_W-1:0] w);
        logic [23:0] prod;
        logic [9:0]  q;
        logic [WSUM_W-1:0] q7;
        logic [WSUM_W-1:0] r;
        prod = 24'(w) * 24'd2341;
        q    = prod[23:14];
        q7   = (WSUM_W'(q) << 3) - WSUM_W'(q);
        r    = w - q7;
        return r[WDAY_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/gds_cal.sv =====
// Calendar logic: validity, leap year, month length, neighbor dates and weekday sum.
module gds_cal (
    input  logic [gds_pkg::YEAR_W-1:0]  year,
    input  logic [gds_pkg::MONTH_W-1:0] month,
    input  logic [gds_pkg::DAY_W-1:0]   day,
    input  logic [gds_pkg::Y400_W-1:0]  year_mod400,
    output gds_pkg::gds_cal_t           cal
);
    import gds_pkg::*;

    logic [Y100_W-1:0]  y100;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               valid;
    logic [Y400_W-1:0]  y4;
    logic [Y100_W-1:0]  y4_100;
    logic [MONTH_W-1:0] month_dn;
    logic [DAY_W-1:0]   len_dn;

    // Leap year and month length from the raw year
    assign y100 = {mod25(year_mod400[Y400_W-1:2]), year_mod400[1:0]};
    assign leap = (year_mod400 == '0) || ((year[1:0] == 2'd0) && (y100 != '0));
    assign len  = BASE_LEN[month] + DAY_W'((month == MONTH_FEB) && leap);

    assign valid = (year <= YEAR_MAX) && (len != '0) && (day != '0) && (day <= len);

    // January and February count in the previous year for the weekday
    always_comb
    begin
        if ((month == MONTH_JAN) || (month == MONTH_FEB))
            y4 = (year_mod400 == '0) ? 9'd399 : year_mod400 - 9'd1;
        else
            y4 = year_mod400;
    end
    assign y4_100 = {mod25(y4[Y400_W-1:2]), y4[1:0]};

    // Length of the month before, within the same year
    assign month_dn = month - 4'd1;
    assign len_dn   = BASE_LEN[month_dn] + DAY_W'((month_dn == MONTH_FEB) && leap);

    // Assemble neighbor dates; an invalid date maps to itself
    always_comb
    begin
        cal              = '0;
        cal.date_valid   = valid;
        cal.leap_year    = leap;
        cal.month_length = len;
        cal.wsum         = WSUM_W'(day) + WSUM_W'(MON_OFS[month])
                         + (WSUM_W'(y4[1:0]) << 2) + WSUM_W'(y4[1:0])
                         + (WSUM_W'(y4_100) << 2)
                         + (WSUM_W'(y4) << 2) + (WSUM_W'(y4) << 1);
        cal.next_year    = year;
        cal.next_month   = month;
        cal.next_day     = day;
        cal.prev_year    = year;
        cal.prev_month   = month;
        cal.prev_day     = day;
        if (valid)
        begin
            if (day == len)
            begin
                cal.next_day = DAY_FIRST;
                if (month == MONTH_DEC)
                begin
                    cal.next_month = MONTH_JAN;
                    cal.next_year  = (year == YEAR_MAX) ? '0 : year + 14'd1;
                end
                else
                begin
                    cal.next_month = month + 4'd1;
                end
            end
            else
            begin
                cal.next_day = day + 5'd1;
            end

            if (day == DAY_FIRST)
            begin
                if (month == MONTH_JAN)
                begin
                    cal.prev_month = MONTH_DEC;
                    cal.prev_year  = (year == '0) ? YEAR_MAX : year - 14'd1;
                    cal.prev_day   = DEC_LEN;
                end
                else
                begin
                    cal.prev_month = month_dn;
                    cal.prev_day   = len_dn;
                end
            end
            else
            begin
                cal.prev_day = day - 5'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/gregorian_date_step.sv =====
// Gregorian date step: one date per cycle in, validity, leap year, weekday and neighbor dates out.
// Throughput: one date per cycle; busy is never raised, results stream with no stall.
// Stages: input register, year mod 400, calendar logic, weekday mod 7 into the result register.
// Reset: rst_n clears all stage valid bits and done asynchronously; payload is not reset.
module gregorian_date_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gds_pkg::YEAR_W-1:0]   year_in,
    input  logic [gds_pkg::MONTH_W-1:0]  month_in,
    input  logic [gds_pkg::DAY_W-1:0]    day_in,
    output logic                         done,
    output logic                         date_valid,
    output logic                         leap_year,
    output logic [gds_pkg::DAY_W-1:0]    month_length,
    output logic [gds_pkg::WDAY_W-1:0]   weekday,
    output logic [gds_pkg::YEAR_W-1:0]   next_year,
    output logic [gds_pkg::MONTH_W-1:0]  next_month,
    output logic [gds_pkg::DAY_W-1:0]    next_day,
    output logic [gds_pkg::YEAR_W-1:0]   prev_year,
    output logic [gds_pkg::MONTH_W-1:0]  prev_month,
    output logic [gds_pkg::DAY_W-1:0]    prev_day
);
    import gds_pkg::*;

    logic                in_vld_reg;
    logic [YEAR_W-1:0]   in_year_reg;
    logic [MONTH_W-1:0]  in_month_reg;
    logic [DAY_W-1:0]    in_day_reg;

    logic                ym_vld_reg;
    logic [YEAR_W-1:0]   ym_year_reg;
    logic [MONTH_W-1:0]  ym_month_reg;
    logic [DAY_W-1:0]    ym_day_reg;
    logic [Y400_W-1:0]   y400_next;
    logic [Y400_W-1:0]   y400_reg;

    gds_cal_t            cal_next;
    gds_cal_t            cal_reg;
    logic                cal_vld_reg;

    logic [WDAY_W-1:0]   weekday_next;
    logic                done_reg;
    gds_cal_t            res_reg;
    logic [WDAY_W-1:0]   weekday_reg;

    logic                accept;

    // Every cycle is open for a new date
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign y400_next = mod400(in_year_reg);

    gds_cal u_cal (
        .year        (ym_year_reg),
        .month       (ym_month_reg),
        .day         (ym_day_reg),
        .year_mod400 (y400_reg),
        .cal         (cal_next)
    );

    assign weekday_next = mod7(cal_reg.wsum);

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            ym_vld_reg  <= 1'b0;
            cal_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= accept;
            ym_vld_reg  <= in_vld_reg;
            cal_vld_reg <= ym_vld_reg;
            done_reg    <= cal_vld_reg;
        end
    end

    // Advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_year_reg  <= year_in;
            in_month_reg <= month_in;
            in_day_reg   <= day_in;
        end
        ym_year_reg  <= in_year_reg;
        ym_month_reg <= in_month_reg;
        ym_day_reg   <= in_day_reg;
        y400_reg     <= y400_next;
        cal_reg      <= cal_next;
        res_reg      <= cal_reg;
        weekday_reg  <= weekday_next;
    end

    assign done         = done_reg;
    assign date_valid   = res_reg.date_valid;
    assign leap_year    = res_reg.leap_year;
    assign month_length = res_reg.month_length;
    assign weekday      = weekday_reg;
    assign next_year    = res_reg.next_year;
    assign next_month   = res_reg.next_month;
    assign next_day     = res_reg.next_day;
    assign prev_year    = res_reg.prev_year;
    assign prev_month   = res_reg.prev_month;
    assign prev_day     = res_reg.prev_day;

    // Each transfer in yields exactly one transfer out
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted date produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result without an accepted date");

    a_invalid_self: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !date_valid) |-> (next_year == prev_year && next_month == prev_month
                                   && next_day == prev_day))
        else $error("invalid date neighbors differ");

    a_valid_days: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_valid) |-> (next_day != '0 && prev_day != '0 && month_length != '0))
        else $error("valid date with zero day field");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (weekday != 3'd7))
        else $error("weekday out of range");

endmodule
